[rtl/dms_pkg.sv]
// Shared types, widths and arithmetic helpers for the disk motion step pipeline.
`timescale 1ns / 1ps
`default_nettype none
package dms_pkg;

  // Widths of the division and root sequences.
  localparam int unsigned SQRT_N = 32;  // root bits of a 63-bit radicand
  localparam int unsigned T_W    = 36;  // force_gain * 10 quotient bits
  localparam int unsigned F1_W   = 52;  // T * 2^16 / r quotient bits
  localparam int unsigned F2_W   = 63;  // f1 * 2^16 / r quotient bits, capped
  localparam int unsigned ACC_W  = 33;  // f * |d| / r quotient bits, capped

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIELD_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FIELD_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FORCE_GAIN   = 2'd2;
  localparam logic [1:0] CFG_DRAG         = 2'd3;

  // Everything one item carries down the pipeline; index 0 is x, 1 is y.
  typedef struct packed {
    logic [1:0][31:0] p;      // position, signed Q16.16
    logic [1:0][31:0] v;      // velocity, signed Q16.16
    logic [1:0]       dn;     // offset to centre is negative
    logic [1:0][32:0] ad;     // magnitude of offset to centre
    logic [1:0]       bnc;    // velocity is negated at an edge
    logic [37:0]      k;      // drag factor times radius, Q6.32
    logic [1:0]       sh;     // pre-shift of the root operands
    logic [6:0]       mt;     // mass in tenths, never zero
    logic [1:0][30:0] ab;     // shifted offset magnitudes
    logic [1:0][61:0] aa;     // their squares
    logic [62:0]      sq_x;   // root remainder
    logic [62:0]      sq_res; // root result
    logic [35:0]      t_num;  // force_gain * 10
    logic [6:0]       t_rem;
    logic [35:0]      t_q;
    logic [33:0]      r;      // distance
    logic             at;     // distance is zero
    logic [33:0]      d_rem;
    logic [62:0]      d_num;
    logic [62:0]      q;
    logic             ovf;
    logic [1:0][64:0] p0;
    logic [1:0][63:0] p1;
    logic [1:0][95:0] nn;
    logic [1:0]       aovf;
    logic [1:0][33:0] arem;
    logic [1:0][32:0] alo;
    logic [1:0][32:0] aq;
    logic [1:0][31:0] av;
    logic [1:0][63:0] pl;
    logic [1:0][37:0] ph;
    logic [1:0][38:0] dv;
  } item_t;

  // Saturate a wide signed value to the 32-bit coordinate range.
  function automatic logic [31:0] sat32(logic signed [41:0] x);
    logic [31:0] res;
    if (x > 42'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (x < -42'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  // Add or subtract an unsigned magnitude, then saturate.
  function automatic logic [31:0] add_mag(logic [31:0] v, logic [38:0] m, logic sub);
    logic signed [41:0] mm;
    logic signed [41:0] s;
    mm = $signed({3'b0, m});
    s  = $signed({{10{v[31]}}, v}) + (sub ? -mm : mm);
    return sat32(s);
  endfunction

  // Negate with saturation.
  function automatic logic [31:0] neg_sat(logic [31:0] v);
    logic signed [41:0] s;
    s = -$signed({{10{v[31]}}, v});
    return sat32(s);
  endfunction

  // One step of the digit-by-digit square root.
  function automatic item_t sqrt_step(item_t it, logic [4:0] j);
    logic [5:0]  sa;
    logic [62:0] bt;
    logic [63:0] trial;
    sa    = 6'd62 - {j, 1'b0};
    bt    = 63'd1 << sa;
    trial = {1'b0, it.sq_res} + {1'b0, bt};
    if ({1'b0, it.sq_x} >= trial) begin
      it.sq_x   = it.sq_x - trial[62:0];
      it.sq_res = (it.sq_res >> 1) + bt;
    end else begin
      it.sq_res = it.sq_res >> 1;
    end
    return it;
  endfunction

  // One restoring step of force_gain * 10 / mass.
  function automatic item_t t_step(item_t it, logic [5:0] pos);
    logic [7:0] s;
    s = {it.t_rem, it.t_num[pos]};
    if (s >= {1'b0, it.mt}) begin
      s = s - {1'b0, it.mt};
      it.t_q[pos] = 1'b1;
    end
    it.t_rem = s[6:0];
    return it;
  endfunction

  // One restoring step of a division by the distance.
  function automatic item_t div_r_step(item_t it, logic [5:0] pos);
    logic [34:0] s;
    s = {it.d_rem, it.d_num[pos]};
    if (s >= {1'b0, it.r}) begin
      s = s - {1'b0, it.r};
      it.q[pos] = 1'b1;
    end
    it.d_rem = s[33:0];
    return it;
  endfunction

  // One restoring step of the per-axis attraction division.
  function automatic item_t acc_step(item_t it, logic ax, logic [5:0] pos);
    logic [34:0] s;
    s = {it.arem[ax], it.alo[ax][pos]};
    if (s >= {1'b0, it.r}) begin
      s = s - {1'b0, it.r};
      it.aq[ax][pos] = 1'b1;
    end
    it.arem[ax] = s[33:0];
    return it;
  endfunction

endpackage
`default_nettype wire

[rtl/disk_motion_step.sv]
// Top level: pipelined one-frame update of a disk's position and velocity.
// Throughput is one item per cycle while the result item is not stalled;
// the bit-per-stage divisions and the root set the depth.
// A stalled result item freezes every stage, so in_stall is out_stall while out_valid is high.
// Reset clears all stage valid bits and loads the default field, force and drag settings.
`timescale 1ns / 1ps
`default_nettype none
module disk_motion_step (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_vel_x,
  input  wire logic [31:0] in_vel_y,
  input  wire logic [5:0]  in_disk_radius,
  input  wire logic [6:0]  in_mass_tenths,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_new_pos_x,
  output logic [31:0]      out_new_pos_y,
  output logic [31:0]      out_new_vel_x,
  output logic [31:0]      out_new_vel_y,
  output logic             out_bounced_x,
  output logic             out_bounced_y,
  output logic             out_at_centre
);
  import dms_pkg::*;

  // Stage map.
  localparam int unsigned S_IN  = 0;
  localparam int unsigned S_SQR = 1;
  localparam int unsigned S_SUM = 2;
  localparam int unsigned S_SQ0 = 3;
  localparam int unsigned SQ_N  = (T_W > SQRT_N) ? T_W : SQRT_N;
  localparam int unsigned S_R   = S_SQ0 + SQ_N;
  localparam int unsigned S_F1  = S_R + 1;
  localparam int unsigned S_F2I = S_F1 + F1_W;
  localparam int unsigned S_F2  = S_F2I + 1;
  localparam int unsigned S_M1  = S_F2 + F2_W;
  localparam int unsigned S_M2  = S_M1 + 1;
  localparam int unsigned S_A0  = S_M2 + 1;
  localparam int unsigned S_ACC = S_A0 + 1;
  localparam int unsigned S_V1  = S_ACC + ACC_W;
  localparam int unsigned S_D0  = S_V1 + 1;
  localparam int unsigned S_D1  = S_D0 + 1;
  localparam int unsigned S_D2  = S_D1 + 1;
  localparam int unsigned S_D3  = S_D2 + 1;
  localparam int unsigned S_D4  = S_D3 + 1;
  localparam int unsigned S_OUT = S_D4 + 1;
  localparam int unsigned NST   = S_OUT + 1;

  logic [12:0] field_width_r;
  logic [12:0] field_height_r;
  logic [31:0] force_gain_r;
  logic [31:0] drag_r;

  logic [NST-1:0] vld_r;
  item_t          st_r   [NST];
  item_t          st_nxt [NST];
  logic           adv;

  // The whole pipe moves whenever the output register is free or being taken.
  assign adv      = !vld_r[S_OUT] || !out_stall;
  assign in_stall = !adv;

  // Stage logic for every register of the pipe.
  always_comb begin
    logic [1:0][31:0]  pin;
    logic [1:0][31:0]  vin;
    logic [1:0][12:0]  fsz;
    logic signed [33:0] d;
    logic signed [33:0] ps;
    logic signed [33:0] lo_s;
    logic signed [33:0] hi_s;
    logic signed [13:0] ed;
    logic [32:0]       mx;
    logic [62:0]       f;
    logic [32:0]       mg;
    item_t             tmp;

    pin = {in_pos_y, in_pos_x};
    vin = {in_vel_y, in_vel_x};
    fsz = {field_height_r, field_width_r};
    d = '0;
    ps = '0;
    lo_s = '0;
    hi_s = '0;
    ed = '0;
    mg = '0;

    for (int i = 1; i < NST; i++) begin
      st_nxt[i] = st_r[i-1];
    end

    // Entry: offsets to the centre, edge tests, root pre-shift, mass, force numerator and drag factor.
    tmp = '0;
    lo_s = $signed({12'b0, in_disk_radius, 16'b0});
    for (int ax = 0; ax < 2; ax++) begin
      d  = $signed({6'b0, fsz[ax][12:1], 16'b0}) - $signed({{2{pin[ax][31]}}, pin[ax]});
      ps = $signed({{2{pin[ax][31]}}, pin[ax]});
      ed = $signed({1'b0, fsz[ax]}) - $signed({8'b0, in_disk_radius});
      hi_s = $signed({{4{ed[13]}}, ed, 16'b0});
      tmp.p[ax]   = pin[ax];
      tmp.v[ax]   = vin[ax];
      tmp.dn[ax]  = d[33];
      tmp.ad[ax]  = d[33] ? (~d[32:0] + 33'd1) : d[32:0];
      tmp.bnc[ax] = (ps < lo_s) || (ps >= hi_s);
    end
    mx = (tmp.ad[0] > tmp.ad[1]) ? tmp.ad[0] : tmp.ad[1];
    tmp.sh = mx[32] ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
    for (int ax = 0; ax < 2; ax++) begin
      tmp.ab[ax] = 31'(tmp.ad[ax] >> tmp.sh);
    end
    tmp.mt    = (in_mass_tenths == 7'd0) ? 7'd1 : in_mass_tenths;
    tmp.t_num = {1'b0, force_gain_r, 3'b0} + {3'b0, force_gain_r, 1'b0};
    tmp.k     = 38'(drag_r) * 38'(in_disk_radius);
    st_nxt[S_IN] = tmp;

    // Squares of the shifted offsets.
    for (int ax = 0; ax < 2; ax++) begin
      st_nxt[S_SQR].aa[ax] = 62'(st_r[S_SQR-1].ab[ax]) * 62'(st_r[S_SQR-1].ab[ax]);
    end

    // Radicand, and clear the root and mass division workspaces.
    st_nxt[S_SUM].sq_x   = {1'b0, st_r[S_SUM-1].aa[0]} + {1'b0, st_r[S_SUM-1].aa[1]};
    st_nxt[S_SUM].sq_res = '0;
    st_nxt[S_SUM].t_rem  = '0;
    st_nxt[S_SUM].t_q    = '0;

    // Root and force over mass run side by side, one bit per stage.
    for (int j = 0; j < SQ_N; j++) begin
      tmp = st_r[S_SQ0+j-1];
      if (j < SQRT_N) begin
        tmp = sqrt_step(tmp, 5'(j));
      end
      if (j < T_W) begin
        tmp = t_step(tmp, 6'(T_W - 1 - j));
      end
      st_nxt[S_SQ0+j] = tmp;
    end

    // Distance, zero test, and the first division by it.
    tmp = st_r[S_R-1];
    tmp.r     = 34'(tmp.sq_res[31:0]) << tmp.sh;
    tmp.at    = (tmp.r == 34'd0);
    tmp.d_num = {11'b0, tmp.t_q, 16'b0};
    tmp.d_rem = '0;
    tmp.q     = '0;
    st_nxt[S_R] = tmp;

    for (int j = 0; j < F1_W; j++) begin
      st_nxt[S_F1+j] = div_r_step(st_r[S_F1+j-1], 6'(F1_W - 1 - j));
    end

    // Second division: overflow past the cap is detected from the top bits.
    tmp = st_r[S_F2I-1];
    tmp.ovf   = {29'b0, tmp.q[51:47]} >= tmp.r;
    tmp.d_rem = 34'(tmp.q[51:47]);
    tmp.d_num = {tmp.q[46:0], 16'b0};
    tmp.q     = '0;
    st_nxt[S_F2I] = tmp;

    for (int j = 0; j < F2_W; j++) begin
      st_nxt[S_F2+j] = div_r_step(st_r[S_F2+j-1], 6'(F2_W - 1 - j));
    end

    // Force times offset, split into two partial products per axis.
    tmp = st_r[S_M1-1];
    f = tmp.ovf ? {63{1'b1}} : tmp.q;
    for (int ax = 0; ax < 2; ax++) begin
      tmp.p0[ax] = 65'(f[31:0]) * 65'(tmp.ad[ax]);
      tmp.p1[ax] = 64'(f[62:32]) * 64'(tmp.ad[ax]);
    end
    st_nxt[S_M1] = tmp;

    for (int ax = 0; ax < 2; ax++) begin
      st_nxt[S_M2].nn[ax] = {31'b0, st_r[S_M2-1].p0[ax]} + {st_r[S_M2-1].p1[ax], 32'b0};
    end

    // Attraction division setup; a quotient past the cap saturates the velocity anyway.
    tmp = st_r[S_A0-1];
    for (int ax = 0; ax < 2; ax++) begin
      tmp.aovf[ax] = tmp.nn[ax][95:33] >= {29'b0, tmp.r};
      tmp.arem[ax] = tmp.nn[ax][66:33];
      tmp.alo[ax]  = tmp.nn[ax][32:0];
      tmp.aq[ax]   = '0;
    end
    st_nxt[S_A0] = tmp;

    for (int j = 0; j < ACC_W; j++) begin
      tmp = st_r[S_ACC+j-1];
      tmp = acc_step(tmp, 1'b0, 6'(ACC_W - 1 - j));
      tmp = acc_step(tmp, 1'b1, 6'(ACC_W - 1 - j));
      st_nxt[S_ACC+j] = tmp;
    end

    // Apply the attraction unless the disk sits on the centre.
    tmp = st_r[S_V1-1];
    for (int ax = 0; ax < 2; ax++) begin
      mg = tmp.aovf[ax] ? {33{1'b1}} : tmp.aq[ax];
      if (!tmp.at) begin
        tmp.v[ax] = add_mag(tmp.v[ax], {6'b0, mg}, tmp.dn[ax]);
      end
    end
    st_nxt[S_V1] = tmp;

    // Drag: magnitude, product with the drag factor, then reduce toward zero.
    for (int ax = 0; ax < 2; ax++) begin
      st_nxt[S_D0].av[ax] = st_r[S_D0-1].v[ax][31] ? (~st_r[S_D0-1].v[ax] + 32'd1)
                                                   : st_r[S_D0-1].v[ax];
      st_nxt[S_D1].pl[ax] = 64'(st_r[S_D1-1].av[ax]) * 64'(st_r[S_D1-1].k[31:0]);
      st_nxt[S_D1].ph[ax] = 38'(st_r[S_D1-1].av[ax]) * 38'(st_r[S_D1-1].k[37:32]);
      st_nxt[S_D2].dv[ax] = {7'b0, st_r[S_D2-1].pl[ax][63:32]} + {1'b0, st_r[S_D2-1].ph[ax]};
      st_nxt[S_D3].v[ax]  = add_mag(st_r[S_D3-1].v[ax], st_r[S_D3-1].dv[ax],
                                    ~st_r[S_D3-1].v[ax][31]);
    end

    // Edge bounce, then move.
    for (int ax = 0; ax < 2; ax++) begin
      if (st_r[S_D4-1].bnc[ax]) begin
        st_nxt[S_D4].v[ax] = neg_sat(st_r[S_D4-1].v[ax]);
      end
      st_nxt[S_OUT].p[ax] = sat32($signed({{10{st_r[S_OUT-1].p[ax][31]}}, st_r[S_OUT-1].p[ax]})
                                + $signed({{10{st_r[S_OUT-1].v[ax][31]}}, st_r[S_OUT-1].v[ax]}));
    end
  end

  // Control state: stage valid bits and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r          <= '0;
      field_width_r  <= 13'd800;
      field_height_r <= 13'd600;
      force_gain_r   <= 32'd1966080;
      drag_r         <= 32'd242877;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[NST-2:0], in_valid};
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FIELD_WIDTH:  field_width_r  <= cfg_wdata[12:0];
          CFG_FIELD_HEIGHT: field_height_r <= cfg_wdata[12:0];
          CFG_FORCE_GAIN:   force_gain_r   <= cfg_wdata;
          CFG_DRAG:         drag_r         <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Stage payloads move with the valid bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Result item ports.
  assign out_valid     = vld_r[S_OUT];
  assign out_new_pos_x = st_r[S_OUT].p[0];
  assign out_new_pos_y = st_r[S_OUT].p[1];
  assign out_new_vel_x = st_r[S_OUT].v[0];
  assign out_new_vel_y = st_r[S_OUT].v[1];
  assign out_bounced_x = st_r[S_OUT].bnc[0];
  assign out_bounced_y = st_r[S_OUT].bnc[1];
  assign out_at_centre = st_r[S_OUT].at;

  // An accepted item lands in the first stage.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[S_IN])
    else $error("accepted item missing from first stage");

  // A frozen pipe keeps every valid bit.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r == $past(vld_r))
    else $error("valid bits moved during a stall");

  // A moving pipe delivers the last inner stage to the output.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[S_OUT-1] |=> out_valid)
    else $error("item lost before output");

  // Zero distance only happens when the disk sits exactly on the centre.
  a_centre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_centre |-> st_r[S_OUT].ad[0] == 33'd0 && st_r[S_OUT].ad[1] == 33'd0)
    else $error("zero distance with nonzero offset");

endmodule
`default_nettype wire
